@@ design/prsd_pkg.sv @@
// Shared types, codes and helper functions of the relocation stream decoder.
`timescale 1ns / 1ps
package prsd_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_NUM_SEGMENTS = 32;

    localparam logic [2:0] OP_HALF = 3'd0;
    localparam logic [2:0] OP_READ = 3'd1;
    localparam logic [2:0] OP_FLAG_WR = 3'd2;
    localparam logic [2:0] OP_TYPE_WR = 3'd3;
    localparam logic [2:0] OP_SEG_WR = 3'd4;
    localparam logic [2:0] OP_START = 3'd5;

    localparam logic [2:0] PH_CMD = 3'd0;
    localparam logic [2:0] PH_BASE_LO = 3'd1;
    localparam logic [2:0] PH_BASE_HI = 3'd2;
    localparam logic [2:0] PH_OFF_LO = 3'd3;
    localparam logic [2:0] PH_ADDR_LO = 3'd4;
    localparam logic [2:0] PH_ADDR_HI = 3'd5;
    localparam logic [2:0] PH_LO16 = 3'd6;
    localparam logic [2:0] PH_READ = 3'd7;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_BASE_SIZE = 3'd1;
    localparam logic [2:0] ERR_OFFSET_SIZE = 3'd2;
    localparam logic [2:0] ERR_TARGET = 3'd3;
    localparam logic [2:0] ERR_ADDRESS = 3'd4;
    localparam logic [2:0] ERR_LO16_MODE = 3'd5;
    localparam logic [2:0] ERR_TYPE = 3'd6;

    localparam logic [2:0] REG_FLAG_WIDTH = 3'd0;
    localparam logic [2:0] REG_SEG_WIDTH = 3'd1;
    localparam logic [2:0] REG_TYPE_WIDTH = 3'd2;
    localparam logic [2:0] REG_ADDR_LOW = 3'd3;
    localparam logic [2:0] REG_ADDR_HIGH = 3'd4;

    localparam logic [31:0] JUMP_TOP_MASK = 32'hFC000000;
    localparam logic [31:0] JUMP_LOW_MASK = 32'h03FFFFFF;
    localparam logic [31:0] J_OPCODE = 32'h08000000;
    localparam logic [31:0] JAL_OPCODE = 32'h0C000000;
    localparam logic [31:0] HI_CARRY = 32'h00010000;
    localparam logic [7:0] SIZE_MASK = 8'h06;
    localparam logic [7:0] MODE_MASK = 8'h38;

    typedef struct packed {
        logic [31:0] reloc_base;
        logic [7:0]  off_seg;
        logic [31:0] low_addend;
        logic [7:0]  prev_type;
        logic [2:0]  phase;
        logic [15:0] pend_cmd;
        logic [31:0] pend_target;
        logic [31:0] pend_addr;
    } prsd_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] word;
        logic [2:0]  error_code;
        logic        last;
    } prsd_result_t;

    function automatic logic [15:0] bits_at(input logic [15:0] cmd, input logic [5:0] pos,
                                            input logic [3:0] w);
        logic [15:0] v;
        begin
            v = 16'd0;
            if (pos < 6'd16)
            begin
                v = (cmd >> pos[3:0]) & ((16'd1 << w) - 16'd1);
            end
            return v;
        end
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [5:0] n);
        logic [4:0] nn;
        begin
            nn = (n > 6'd31) ? 5'd31 : n[4:0];
            return $unsigned($signed(v) >>> nn);
        end
    endfunction

endpackage

@@ design/packed_relocation_stream_decoder_unit.sv @@
// Top level of the packed relocation stream decoder.
`timescale 1ns / 1ps
// Takes one item per cycle while in_stall is low: an accepted item reads the flag table,
// the type table and two copies of the segment base table in the cycle it is accepted,
// and is decoded in the next cycle, when its up to two result items enter an eight-entry
// result queue, from which they are presented in order.
// Table reads are addressed from the state the previous item leaves, so items
// follow each other without gaps. Input stall rises while more than four results are queued.
// Entries of the tables never written read back as arbitrary data.
module packed_relocation_stream_decoder_unit #(
    parameter int TABLE_DEPTH = prsd_pkg::DEFAULT_TABLE_DEPTH,
    parameter int NUM_SEGMENTS = prsd_pkg::DEFAULT_NUM_SEGMENTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] data,
    input  logic [7:0]  table_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] address,
    output logic [31:0] word,
    output logic [2:0]  error_code,
    output logic        last
);
    import prsd_pkg::*;

    localparam int TAW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int SAW = NUM_SEGMENTS > 1 ? $clog2(NUM_SEGMENTS) : 1;

    logic [3:0]  flag_width_reg, seg_width_reg, type_width_reg;
    logic [31:0] addr_low_reg, addr_high_reg;
    prsd_state_t st_reg, st_next;
    logic        s2_valid_reg;
    logic [2:0]  s2_op_reg;
    logic [31:0] s2_data_reg;
    logic        flag_ok_reg, type_ok_reg, sega_ok_reg, segb_ok_reg;
    logic        accept;
    logic [15:0] flag_idx, type_idx, sega_idx;
    logic [7:0]  flag_rd, type_rd;
    logic [31:0] sega_rd, segb_rd;
    logic [7:0]  flag_v, type_v;
    logic [31:0] sega_v, segb_v;
    logic        flag_we, type_we, seg_we;
    logic        q_almost_full;
    prsd_result_t res0, res1, head;
    logic [1:0]  res_count;

    assign accept = in_valid && !in_stall;
    assign in_stall = q_almost_full;

    assign flag_idx = bits_at((st_next.phase == PH_CMD) ? data[15:0] : st_next.pend_cmd,
                              6'd0, flag_width_reg);
    assign type_idx = bits_at(st_next.pend_cmd,
                              {2'b00, flag_width_reg} + {2'b00, seg_width_reg},
                              type_width_reg);
    assign sega_idx = bits_at(data[15:0], {2'b00, flag_width_reg}, seg_width_reg);

    assign flag_we = accept && op == OP_FLAG_WR && 32'(table_index) < TABLE_DEPTH;
    assign type_we = accept && op == OP_TYPE_WR && 32'(table_index) < TABLE_DEPTH;
    assign seg_we = accept && op == OP_SEG_WR && 32'(table_index) < NUM_SEGMENTS;

    prsd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_flag_ram (
        .clk(clk), .we(flag_we), .waddr(TAW'(table_index)), .wdata(data[7:0]),
        .re(accept), .raddr(flag_idx[TAW-1:0]), .rdata(flag_rd)
    );

    prsd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_type_ram (
        .clk(clk), .we(type_we), .waddr(TAW'(table_index)), .wdata(data[7:0]),
        .re(accept), .raddr(type_idx[TAW-1:0]), .rdata(type_rd)
    );

    prsd_ram #(.WIDTH(32), .DEPTH(NUM_SEGMENTS)) u_seg_ram_a (
        .clk(clk), .we(seg_we), .waddr(SAW'(table_index)), .wdata(data),
        .re(accept), .raddr(sega_idx[SAW-1:0]), .rdata(sega_rd)
    );

    prsd_ram #(.WIDTH(32), .DEPTH(NUM_SEGMENTS)) u_seg_ram_b (
        .clk(clk), .we(seg_we), .waddr(SAW'(table_index)), .wdata(data),
        .re(accept), .raddr(SAW'(st_next.off_seg)), .rdata(segb_rd)
    );

    assign flag_v = flag_ok_reg ? flag_rd : 8'd0;
    assign type_v = type_ok_reg ? type_rd : 8'd0;
    assign sega_v = sega_ok_reg ? sega_rd : 32'd0;
    assign segb_v = segb_ok_reg ? segb_rd : 32'd0;

    prsd_step u_step (
        .valid(s2_valid_reg), .op(s2_op_reg), .data(s2_data_reg),
        .flag_width(flag_width_reg), .seg_width(seg_width_reg), .type_width(type_width_reg),
        .addr_low(addr_low_reg), .addr_high(addr_high_reg),
        .st(st_reg), .flag_v(flag_v), .type_v(type_v), .seg_a(sega_v), .seg_b(segb_v),
        .st_next(st_next), .res0(res0), .res1(res1), .count(res_count)
    );

    prsd_out_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push_count(res_count), .push0(res0), .push1(res1),
        .almost_full(q_almost_full), .out_valid(out_valid), .out_stall(out_stall),
        .head(head)
    );

    assign kind = head.kind;
    assign address = head.address;
    assign word = head.word;
    assign error_code = head.error_code;
    assign last = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_width_reg <= 4'd1;
            seg_width_reg <= 4'd1;
            type_width_reg <= 4'd1;
            addr_low_reg <= 32'd0;
            addr_high_reg <= 32'hFFFFFFFF;
            st_reg <= '{32'd0, 8'd0, 32'd0, 8'hFF, PH_CMD, 16'd0, 32'd0, 32'd0};
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            s2_valid_reg <= accept;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FLAG_WIDTH: flag_width_reg <= cfg_data[3:0];
                    REG_SEG_WIDTH: seg_width_reg <= cfg_data[3:0];
                    REG_TYPE_WIDTH: type_width_reg <= cfg_data[3:0];
                    REG_ADDR_LOW: addr_low_reg <= cfg_data;
                    REG_ADDR_HIGH: addr_high_reg <= cfg_data;
                    default: addr_high_reg <= addr_high_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_op_reg <= op;
            s2_data_reg <= data;
            flag_ok_reg <= 32'(flag_idx) < TABLE_DEPTH;
            type_ok_reg <= 32'(type_idx) < TABLE_DEPTH;
            sega_ok_reg <= 32'(sega_idx) < NUM_SEGMENTS;
            segb_ok_reg <= 32'(st_next.off_seg) < NUM_SEGMENTS;
        end
    end
endmodule

@@ design/prsd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module prsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/prsd_step.sv @@
// Decode and patch step: next state and up to two result items for one item.
`timescale 1ns / 1ps
module prsd_step (
    input  logic                  valid,
    input  logic [2:0]            op,
    input  logic [31:0]           data,
    input  logic [3:0]            flag_width,
    input  logic [3:0]            seg_width,
    input  logic [3:0]            type_width,
    input  logic [31:0]           addr_low,
    input  logic [31:0]           addr_high,
    input  prsd_pkg::prsd_state_t st,
    input  logic [7:0]            flag_v,
    input  logic [7:0]            type_v,
    input  logic [31:0]           seg_a,
    input  logic [31:0]           seg_b,
    output prsd_pkg::prsd_state_t st_next,
    output prsd_pkg::prsd_result_t res0,
    output prsd_pkg::prsd_result_t res1,
    output logic [1:0]            count
);
    import prsd_pkg::*;

    function automatic logic addr_ok(input logic [31:0] a, input logic [31:0] lo,
                                     input logic [31:0] hi);
        begin
            return (a >= lo) && (a <= hi);
        end
    endfunction

    prsd_result_t res [2];

    always_comb
    begin
        logic [15:0] h;
        logic [7:0]  size;
        logic [7:0]  mode;
        logic [5:0]  sh2;
        logic [5:0]  sh3;
        logic [31:0] r;
        logic [31:0] a;
        logic [31:0] w;
        logic [15:0] fld;
        logic [31:0] sr;
        logic        do_finish;
        logic        quiet;
        logic        emit_write;
        logic [1:0]  n;

        st_next = st;
        h = data[15:0];
        size = flag_v & SIZE_MASK;
        mode = flag_v & MODE_MASK;
        sh2 = {2'b00, flag_width} + {2'b00, seg_width};
        sh3 = sh2 + {2'b00, type_width};
        r = 32'd0;
        a = 32'd0;
        w = data;
        fld = 16'd0;
        sr = 32'd0;
        do_finish = 1'b0;
        quiet = 1'b0;
        emit_write = 1'b0;
        n = 2'd0;
        res[0] = '0;
        res[1] = '0;

        if (valid)
        begin
            case (op)
                OP_HALF:
                begin
                    case (st.phase)
                        PH_CMD:
                        begin
                            st_next.pend_cmd = h;
                            if (!flag_v[0])
                            begin
                                fld = bits_at(h, {2'b00, flag_width}, seg_width);
                                st_next.off_seg = fld[7:0];
                                if (size == 8'd0)
                                begin
                                    st_next.reloc_base = (sh2 >= 6'd16) ? 32'd0
                                                         : {16'd0, h >> sh2[3:0]};
                                end
                                else if (size == 8'd4)
                                begin
                                    st_next.phase = PH_BASE_LO;
                                end
                                else
                                begin
                                    res[0] = '{KIND_ERROR, 32'd0, 32'd0, ERR_BASE_SIZE, 1'b0};
                                    n = 2'd1;
                                    st_next.reloc_base = 32'd0;
                                end
                            end
                            else
                            begin
                                st_next.pend_target = seg_a;
                                if (!addr_ok(seg_a, addr_low, addr_high))
                                begin
                                    res[0] = '{KIND_ERROR, seg_a, 32'd0, ERR_TARGET, 1'b0};
                                    n = 2'd1;
                                    st_next.phase = PH_CMD;
                                end
                                else if (size == 8'd0)
                                begin
                                    if (h[15])
                                    begin
                                        r = asr32({16'hFFFF, h}, sh3) | 32'hFFFF0000;
                                    end
                                    else
                                    begin
                                        r = (sh3 >= 6'd16) ? 32'd0 : {16'd0, h >> sh3[3:0]};
                                    end
                                    st_next.reloc_base = st.reloc_base + r;
                                    do_finish = 1'b1;
                                end
                                else if (size == 8'd2)
                                begin
                                    st_next.phase = PH_OFF_LO;
                                end
                                else if (size == 8'd4)
                                begin
                                    st_next.phase = PH_ADDR_LO;
                                end
                                else
                                begin
                                    res[0] = '{KIND_ERROR, 32'd0, 32'd0, ERR_OFFSET_SIZE, 1'b0};
                                    n = 2'd1;
                                    do_finish = 1'b1;
                                    quiet = 1'b1;
                                end
                            end
                        end
                        PH_BASE_LO:
                        begin
                            st_next.pend_addr = {16'd0, h};
                            st_next.phase = PH_BASE_HI;
                        end
                        PH_BASE_HI:
                        begin
                            st_next.reloc_base = {h, st.pend_addr[15:0]};
                            st_next.phase = PH_CMD;
                        end
                        PH_OFF_LO:
                        begin
                            sr = asr32({{16{st.pend_cmd[15]}}, st.pend_cmd}, sh3);
                            r = {sr[15:0], h};
                            st_next.reloc_base = st.reloc_base + r;
                            do_finish = 1'b1;
                        end
                        PH_ADDR_LO:
                        begin
                            st_next.pend_addr = {16'd0, h};
                            st_next.phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI:
                        begin
                            st_next.reloc_base = {h, st.pend_addr[15:0]};
                            do_finish = 1'b1;
                        end
                        PH_LO16:
                        begin
                            st_next.low_addend = {{16{h[15]}}, h};
                            res[0] = '{KIND_READ, st.pend_addr, 32'd0, ERR_NONE, 1'b0};
                            n = 2'd1;
                            st_next.phase = PH_READ;
                        end
                        default:
                        begin
                            st_next.phase = st.phase;
                        end
                    endcase

                    if (do_finish)
                    begin
                        a = st_next.reloc_base + seg_b;
                        if (!addr_ok(a, addr_low, addr_high))
                        begin
                            res[n[0]] = '{KIND_ERROR, a, 32'd0, ERR_ADDRESS, 1'b0};
                            n = n + 2'd1;
                            st_next.phase = PH_CMD;
                        end
                        else
                        begin
                            st_next.pend_addr = a;
                            if (mode == 8'h10)
                            begin
                                st_next.phase = PH_LO16;
                            end
                            else
                            begin
                                if (mode == 8'h00)
                                begin
                                    st_next.low_addend = 32'd0;
                                end
                                else if (mode == 8'h08)
                                begin
                                    if (st.prev_type != 8'h04)
                                    begin
                                        st_next.low_addend = 32'd0;
                                    end
                                end
                                else if (!quiet)
                                begin
                                    res[n[0]] = '{KIND_ERROR, a, 32'd0, ERR_LO16_MODE, 1'b0};
                                    n = n + 2'd1;
                                end
                                res[n[0]] = '{KIND_READ, a, 32'd0, ERR_NONE, 1'b0};
                                n = n + 2'd1;
                                st_next.phase = PH_READ;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (st.phase == PH_READ)
                    begin
                        st_next.phase = PH_CMD;
                        st_next.prev_type = type_v;
                        emit_write = 1'b1;
                        case (type_v)
                            8'd0:
                            begin
                                emit_write = 1'b0;
                            end
                            8'd2:
                            begin
                                w = data + st.pend_target;
                            end
                            8'd3, 8'd6, 8'd7:
                            begin
                                w = (data & JUMP_TOP_MASK)
                                    | ((data + {2'b00, st.pend_target[31:2]}) & JUMP_LOW_MASK);
                                if (type_v == 8'd6)
                                begin
                                    w = (w & JUMP_LOW_MASK) | J_OPCODE;
                                end
                                else if (type_v == 8'd7)
                                begin
                                    w = (w & JUMP_LOW_MASK) | JAL_OPCODE;
                                end
                            end
                            8'd4:
                            begin
                                a = {data[15:0], 16'd0} + st.low_addend + st.pend_target;
                                if (a[15])
                                begin
                                    a = a + HI_CARRY;
                                end
                                w = {data[31:16], a[31:16]};
                            end
                            8'd1, 8'd5:
                            begin
                                w = {data[31:16], data[15:0] + st.pend_target[15:0]};
                            end
                            default:
                            begin
                                res[0] = '{KIND_ERROR, st.pend_addr, 32'd0, ERR_TYPE, 1'b0};
                                n = 2'd1;
                            end
                        endcase
                        if (emit_write)
                        begin
                            res[n[0]] = '{KIND_WRITE, st.pend_addr, w, ERR_NONE, 1'b0};
                            n = n + 2'd1;
                        end
                    end
                end
                OP_START:
                begin
                    st_next = '{32'd0, 8'd0, 32'd0, 8'hFF, PH_CMD, 16'd0, 32'd0, 32'd0};
                end
                default:
                begin
                    st_next = st;
                end
            endcase
        end

        if (n != 2'd0)
        begin
            res[n[1]].last = 1'b1;
        end
        res0 = res[0];
        res1 = res[1];
        count = n;
    end
endmodule

@@ design/prsd_out_queue.sv @@
// Result queue: takes up to two result items a cycle and hands them out one at a time.
`timescale 1ns / 1ps
module prsd_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_count,
    input  prsd_pkg::prsd_result_t push0,
    input  prsd_pkg::prsd_result_t push1,
    output logic                   almost_full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output prsd_pkg::prsd_result_t head
);
    import prsd_pkg::*;

    localparam int QDEPTH = 8;
    localparam int QAW = $clog2(QDEPTH);

    prsd_result_t q_reg [QDEPTH];
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           pop;
    logic [QAW-1:0] wr_plus1;

    assign pop = out_valid && !out_stall;
    assign wr_plus1 = wr_reg + 1'b1;
    assign rd_next = rd_reg + {{(QAW-1){1'b0}}, pop};
    assign wr_next = wr_reg + QAW'(push_count);
    assign cnt_next = cnt_reg + (QAW+1)'(push_count) - (QAW+1)'(pop);
    assign out_valid = cnt_reg != '0;
    assign head = q_reg[rd_reg];
    assign almost_full = cnt_reg > (QAW+1)'(QDEPTH/2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            q_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            q_reg[wr_plus1] <= push1;
        end
    end
endmodule

@@ design/prsd_checker.sv @@
// Port-level checker of the relocation stream decoder and its bind statement.
`timescale 1ns / 1ps
module prsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] word,
    input logic [2:0]  error_code,
    input logic        last
);
    import prsd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(word) && $stable(last))
        else $error("stalled result item changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_READ || kind == KIND_WRITE || kind == KIND_ERROR)
        else $error("undefined result kind");

    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_READ |-> word == 32'd0 && error_code == ERR_NONE && last)
        else $error("malformed read request");

    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WRITE |-> error_code == ERR_NONE && last)
        else $error("write item not final or carries an error");

    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE && word == 32'd0)
        else $error("error item without a code");
endmodule

bind packed_relocation_stream_decoder_unit prsd_checker u_prsd_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .word(word), .error_code(error_code), .last(last)
);
